@@ src/sjgl_pkg.sv @@
// sjgl_pkg: shared types, constants and helpers for the Shift-JIS glyph layout block.
// No dependencies; the pen, glyph and top modules refer to it by scoped names.
`default_nettype none

package sjgl_pkg;

  localparam int SCREEN_W_DEF = 480;
  localparam int SCREEN_H_DEF = 272;

  localparam int ORIGIN_W = 13;
  localparam int POS_W    = 16;

  typedef enum logic {
    REG_ORIGIN_X = 1'b0,
    REG_ORIGIN_Y = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] BYTE_END     = 8'h00;
  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;

  localparam logic [3:0] STEP_HALF = 4'd5;
  localparam logic [3:0] STEP_FULL = 4'd10;
  localparam logic [3:0] STEP_LINE = 4'd10;

  localparam int NUM_GAPS = 18;

  localparam logic [15:0] GAP_FIRST [NUM_GAPS] = '{
    16'hA2AF, 16'hA2C2, 16'hA2D1, 16'hA2EB, 16'hA2FA, 16'hA3A1, 16'hA3BA, 16'hA3DB, 16'hA3FB,
    16'hA4F4, 16'hA5F7, 16'hA6B9, 16'hA6D9, 16'hA7C2, 16'hA7F2, 16'hA8C1, 16'hCFD4, 16'hF4A5
  };

  localparam logic [15:0] GAP_LAST [NUM_GAPS] = '{
    16'hA2B9, 16'hA2C9, 16'hA2DB, 16'hA2F1, 16'hA2FD, 16'hA3AF, 16'hA3C0, 16'hA3E0, 16'hA3FE,
    16'hA4FE, 16'hA5FE, 16'hA6C0, 16'hA6FE, 16'hA7D0, 16'hA7FE, 16'hAB90, 16'hCFFE, 16'hF8AA
  };

  // running total of gap lengths up to and including gap i
  localparam logic [10:0] GAP_SKIP [NUM_GAPS] = '{
    11'd11, 11'd19, 11'd30, 11'd37, 11'd41, 11'd56, 11'd63, 11'd69, 11'd73,
    11'd84, 11'd92, 11'd100, 11'd138, 11'd153, 11'd166, 11'd886, 11'd929, 11'd1959
  };

  // one placed glyph travelling from the pen stage to the glyph stage
  typedef struct packed {
    logic                    wide;
    logic [7:0]              lead;
    logic [7:0]              code;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } item_t;

  function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                      input logic [3:0] b);
    logic signed [POS_W:0] s;
    s = {a[POS_W-1], a} + $signed({{(POS_W-3){1'b0}}, b});
    if (!s[POS_W] && s[POS_W-1]) sat_add = {1'b0, {(POS_W-1){1'b1}}};
    else                         sat_add = s[POS_W-1:0];
  endfunction

  function automatic logic is_lead(input logic [7:0] b);
    is_lead = (b[7:5] == 3'b100) || (b[7:5] == 3'b111);
  endfunction

endpackage

`default_nettype wire

@@ src/sjgl_text_if.sv @@
// sjgl_text_if: byte channel into the glyph layout block.
// Plain valid/ready handshake; no package dependency.
`default_nettype none

interface sjgl_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

@@ src/sjgl_glyph_if.sv @@
// sjgl_glyph_if: glyph placement channel out of the glyph layout block.
// Plain valid/ready handshake; no package dependency.
`default_nettype none

interface sjgl_glyph_if;
  logic               valid;
  logic               ready;
  logic               wide;
  logic [15:0]        glyph_index;
  logic               glyph_missing;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, output wide, output glyph_index, output glyph_missing,
                  output pos_x, output pos_y, input ready);
  modport sink   (input valid, input wide, input glyph_index, input glyph_missing,
                  input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

@@ src/sjgl_pen.sv @@
// sjgl_pen: lead byte tracking, pen position and origin registers; registers each
// placed glyph into the stage register. Uses sjgl_pkg and sjgl_text_if.
`default_nettype none

module sjgl_pen #(
  parameter int SCREEN_W = sjgl_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = sjgl_pkg::SCREEN_H_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  sjgl_text_if.sink                              text,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [sjgl_pkg::ORIGIN_W-1:0]     cfg_data,
  output sjgl_pkg::item_t                        item,
  output logic                                   item_valid,
  input  wire logic                              item_ready
);

  localparam int PW = sjgl_pkg::POS_W;
  localparam logic signed [PW:0] LIM_X = (PW+1)'(SCREEN_W);
  localparam logic signed [PW:0] LIM_Y = (PW+1)'(SCREEN_H);

  logic [sjgl_pkg::ORIGIN_W-1:0] origin_x;
  logic [sjgl_pkg::ORIGIN_W-1:0] origin_y;
  logic                          lead_pending;
  logic [7:0]                    lead_byte;
  logic signed [PW-1:0]          pen_x;
  logic signed [PW-1:0]          pen_y;

  logic                          lead_pending_next;
  logic [7:0]                    lead_byte_next;
  logic signed [PW-1:0]          pen_x_next;
  logic signed [PW-1:0]          pen_y_next;
  logic signed [PW-1:0]          home_x;
  logic signed [PW-1:0]          home_y;
  logic signed [PW-1:0]          cfg_pos;
  logic                          accept;
  logic                          place;
  logic                          emit;
  logic                          emit_wide;

  assign text.ready = !item_valid || item_ready;
  assign accept     = text.valid && text.ready;

  assign home_x  = {{(PW-sjgl_pkg::ORIGIN_W){origin_x[sjgl_pkg::ORIGIN_W-1]}}, origin_x};
  assign home_y  = {{(PW-sjgl_pkg::ORIGIN_W){origin_y[sjgl_pkg::ORIGIN_W-1]}}, origin_y};
  assign cfg_pos = {{(PW-sjgl_pkg::ORIGIN_W){cfg_data[sjgl_pkg::ORIGIN_W-1]}}, cfg_data};

  assign place = ($signed({pen_x[PW-1], pen_x}) < LIM_X) &&
                 ($signed({pen_y[PW-1], pen_y}) < LIM_Y);

  always_comb begin
    lead_pending_next = lead_pending;
    lead_byte_next    = lead_byte;
    pen_x_next        = pen_x;
    pen_y_next        = pen_y;
    emit              = 1'b0;
    emit_wide         = 1'b0;
    priority if (text.in_byte == sjgl_pkg::BYTE_END) begin
      lead_pending_next = 1'b0;
      pen_x_next        = home_x;
      pen_y_next        = home_y;
    end else if (lead_pending) begin
      lead_pending_next = 1'b0;
      emit              = place;
      emit_wide         = 1'b1;
      pen_x_next        = sjgl_pkg::sat_add(pen_x, sjgl_pkg::STEP_FULL);
    end else if (sjgl_pkg::is_lead(text.in_byte)) begin
      lead_pending_next = 1'b1;
      lead_byte_next    = text.in_byte;
    end else if (text.in_byte == sjgl_pkg::BYTE_NEWLINE) begin
      pen_x_next = home_x;
      pen_y_next = sjgl_pkg::sat_add(pen_y, sjgl_pkg::STEP_LINE);
    end else begin
      emit       = place;
      pen_x_next = sjgl_pkg::sat_add(pen_x, sjgl_pkg::STEP_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      lead_pending <= 1'b0;
      lead_byte    <= '0;
      pen_x        <= '0;
      pen_y        <= '0;
      item_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (sjgl_pkg::cfg_reg_t'(cfg_index))
          sjgl_pkg::REG_ORIGIN_X: begin
            origin_x <= cfg_data;
            pen_x    <= cfg_pos;
          end
          sjgl_pkg::REG_ORIGIN_Y: begin
            origin_y <= cfg_data;
            pen_y    <= cfg_pos;
          end
          default: ;
        endcase
      end else if (accept) begin
        lead_pending <= lead_pending_next;
        lead_byte    <= lead_byte_next;
        pen_x        <= pen_x_next;
        pen_y        <= pen_y_next;
      end
      if (accept)          item_valid <= emit;
      else if (item_ready) item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      item.wide  <= emit_wide;
      item.lead  <= lead_byte;
      item.code  <= text.in_byte;
      item.pos_x <= pen_x;
      item.pos_y <= pen_y;
    end
  end

endmodule

`default_nettype wire

@@ src/sjgl_glyph.sv @@
// sjgl_glyph: turns a registered glyph item into a font glyph number (half-width map,
// or Shift-JIS to EUC conversion with font gap skipping) and holds the output register.
// Uses sjgl_pkg and sjgl_glyph_if.
`default_nettype none

module sjgl_glyph (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sjgl_pkg::item_t item,
  input  wire logic            item_valid,
  output logic                 item_ready,
  sjgl_glyph_if.source         glyph
);

  logic [7:0]         hi_a;
  logic [7:0]         row;
  logic [15:0]        c1;
  logic [15:0]        c2;
  logic [15:0]        c3;
  logic [15:0]        euc;
  logic signed [17:0] row_off;
  logic signed [17:0] n0;
  logic signed [17:0] n;
  logic [10:0]        skip;
  logic               in_gap;
  logic [15:0]        full_idx;
  logic               full_missing;
  logic [7:0]         half_idx;
  logic               load;

  assign item_ready = !glyph.valid || glyph.ready;
  assign load       = item_valid && item_ready;

  // lead byte to JIS row, folded onto a 16-bit EUC code
  always_comb begin
    hi_a = (item.lead >= 8'hE0) ? item.lead - 8'h40 : item.lead;
    row  = hi_a - 8'h81;
    c1   = {row[6:0], 1'b0, item.code};
    c2   = (item.code >= 8'h80) ? c1 - 16'd1 : c1;
    c3   = (c2[7:0] >= 8'h9E) ? c2 + 16'h0062 : c2 - 16'h0040;
    euc  = c3 + 16'hA1A1;
  end

  always_comb begin
    row_off = $signed({10'd0, euc[15:8]}) - 18'sd161;
    n0      = row_off * 18'sd94 + $signed({10'd0, euc[7:0]}) - 18'sd161;
    skip    = '0;
    in_gap  = 1'b0;
    // gaps are sorted, so the last one passed carries the running total
    for (int i = 0; i < sjgl_pkg::NUM_GAPS; i++) begin
      if (euc >= sjgl_pkg::GAP_FIRST[i]) begin
        skip = sjgl_pkg::GAP_SKIP[i];
        if (euc <= sjgl_pkg::GAP_LAST[i]) in_gap = 1'b1;
      end
    end
    n            = n0 - $signed({7'd0, skip});
    full_missing = in_gap || n[17];
    full_idx     = full_missing ? 16'd0 : n[15:0];
  end

  always_comb begin
    priority if (item.code < 8'h20) half_idx = 8'd0;
    else if (item.code < 8'h80)     half_idx = item.code - 8'h20;
    else if (item.code < 8'hA0)     half_idx = 8'd0;
    else                            half_idx = item.code - 8'h40;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph.valid <= 1'b0;
    end else if (load) begin
      glyph.valid <= 1'b1;
    end else if (glyph.ready) begin
      glyph.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      glyph.wide          <= item.wide;
      glyph.glyph_index   <= item.wide ? full_idx : {8'd0, half_idx};
      glyph.glyph_missing <= item.wide && full_missing;
      glyph.pos_x         <= item.pos_x;
      glyph.pos_y         <= item.pos_y;
    end
  end

endmodule

`default_nettype wire

@@ src/sjis_glyph_layout.sv @@
// sjis_glyph_layout: Shift-JIS text to glyph placements, one byte per cycle.
// A placed glyph goes from its taken byte into the pen stage register, then into
// the output register after the glyph number logic. Throughput: one byte per cycle
// unless back-pressure stalls; the output register frees each cycle it is taken.
// Reset: origins and pen go to 0, no pending lead byte, both stages empty.
// Uses sjgl_pkg, sjgl_text_if, sjgl_glyph_if, sjgl_pen and sjgl_glyph.
`default_nettype none

module sjis_glyph_layout #(
  parameter int SCREEN_W = sjgl_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = sjgl_pkg::SCREEN_H_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  sjgl_text_if.sink                          text,
  sjgl_glyph_if.source                       glyph,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [sjgl_pkg::ORIGIN_W-1:0] cfg_data
);

  sjgl_pkg::item_t item;
  logic            item_valid;
  logic            item_ready;

  sjgl_pen #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_pen (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  sjgl_glyph u_glyph (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .glyph      (glyph)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for sjis_glyph_layout: Shift-JIS bytes in, glyph placements out.
// Uses sjgl_pkg, sjgl_text_if and sjgl_glyph_if. A local layout predictor or a directed row
// gives the expected placements, and each accepted output transaction is checked against them.
module testbench;

  localparam int SCREEN_W     = 480;
  localparam int SCREEN_H     = 272;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PEN_MAX      = 32767;
  localparam int PEN_MIN      = -32768;

  typedef struct packed {
    logic               wide;
    logic [15:0]        glyph_index;
    logic               glyph_missing;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } placement_t;

  typedef struct {
    logic [7:0] text_byte;
    bit         typed;
    placement_t want;
  } text_row_t;

  // holes in the full-width font, as EUC start code and length
  localparam int GAP_START [18] = '{
    'hA2AF, 'hA2C2, 'hA2D1, 'hA2EB, 'hA2FA, 'hA3A1, 'hA3BA, 'hA3DB, 'hA3FB,
    'hA4F4, 'hA5F7, 'hA6B9, 'hA6D9, 'hA7C2, 'hA7F2, 'hA8C1, 'hCFD4, 'hF4A5
  };
  localparam int GAP_LEN [18] = '{
    11, 8, 11, 7, 4, 15, 7, 6, 4, 11, 8, 8, 38, 15, 13, 720, 43, 1030
  };

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [sjgl_pkg::ORIGIN_W-1:0] cfg_data;

  sjgl_text_if  text_ch ();
  sjgl_glyph_if glyph_ch ();

  sjis_glyph_layout #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) dut (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .glyph     (glyph_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // layout state mirrored from the block
  int         org_col;
  int         org_row;
  int         pen_col;
  int         pen_row;
  bit         lead_held;
  logic [7:0] lead_val;

  placement_t pending_glyphs [$];
  int         errors = 0;
  int         stall_cycles = 0;
  bit         calm = 1'b0;

  text_row_t directed_rows [25] = '{
    '{8'h20, 1'b1, '{1'b0, 16'h0000, 1'b0, 16'sd0,  16'sd0}},
    '{8'h7F, 1'b1, '{1'b0, 16'h005F, 1'b0, 16'sd5,  16'sd0}},
    '{8'h01, 1'b1, '{1'b0, 16'h0000, 1'b0, 16'sd10, 16'sd0}},
    '{8'hA0, 1'b1, '{1'b0, 16'h0060, 1'b0, 16'sd15, 16'sd0}},
    '{8'hDF, 1'b1, '{1'b0, 16'h009F, 1'b0, 16'sd20, 16'sd0}},
    '{8'h81, 1'b0, '0},
    '{8'h40, 1'b1, '{1'b1, 16'h0000, 1'b0, 16'sd25, 16'sd0}},
    '{8'h81, 1'b0, '0},
    '{8'h3F, 1'b1, '{1'b1, 16'h0000, 1'b1, 16'sd35, 16'sd0}},   // below the font
    '{8'h0A, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, '{1'b1, 16'h0000, 1'b1, 16'sd0,  16'sd10}},
    '{8'h81, 1'b0, '0},
    '{8'hAD, 1'b1, '{1'b1, 16'h0000, 1'b1, 16'sd10, 16'sd10}},  // first code of first gap
    '{8'h81, 1'b0, '0},
    '{8'hB8, 1'b0, '0},
    '{8'hEA, 1'b0, '0},
    '{8'hA4, 1'b0, '0},
    '{8'h82, 1'b0, '0},
    '{8'h0A, 1'b0, '0},                                         // newline taken as trail
    '{8'h80, 1'b0, '0},
    '{8'h9F, 1'b0, '0},                                         // lead-range trail
    '{8'h90, 1'b0, '0},
    '{8'h00, 1'b0, '0},                                         // end drops pending lead
    '{8'h41, 1'b1, '{1'b0, 16'h0021, 1'b0, 16'sd0,  16'sd0}}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int sat16(input int a, input int b);
    int s;
    s = a + b;
    if (s > PEN_MAX) s = PEN_MAX;
    if (s < PEN_MIN) s = PEN_MIN;
    return s;
  endfunction

  // SJIS pair -> EUC -> full-width glyph number; returns 1 when the glyph is missing
  function automatic bit kanji_lookup(input logic [7:0] lead, input logic [7:0] trail,
                                      output logic [15:0] idx);
    logic [15:0] code;
    logic [15:0] row;
    int          c;
    int          n;
    int          hi;
    int          lo;
    int          i;
    idx  = '0;
    code = {lead, trail};
    if (code >= 16'hE000) code = code - 16'h4000;
    row  = {8'h00, code[15:8]} - 16'h0081;
    code = (row << 9) + {8'h00, code[7:0]};
    if (code[7:0] >= 8'h80) code = code - 16'h0001;
    if (code[7:0] >= 8'h9E) code = code + 16'h0062;
    else                    code = code - 16'h0040;
    code = code + 16'h2121 + 16'h8080;
    c  = code;
    hi = code[15:8];
    lo = code[7:0];
    n  = (hi - 'hA1) * ('hFF - 'hA1) + lo - 'hA1;
    for (i = 0; i < 18; i++) begin
      if (c >= GAP_START[i]) begin
        if (c <= GAP_START[i] + GAP_LEN[i] - 1) return 1'b1;
        n -= GAP_LEN[i];
      end
    end
    if (n < 0) return 1'b1;
    idx = n[15:0];
    return 1'b0;
  endfunction

  task automatic advance_layout(input logic [7:0] b, output bit placed, output placement_t p);
    bit          on_screen;
    bit          wide;
    bit          missing;
    logic [15:0] idx;
    on_screen = (pen_col < SCREEN_W) && (pen_row < SCREEN_H);
    placed  = 1'b0;
    p       = '0;
    wide    = 1'b0;
    missing = 1'b0;
    idx     = '0;
    if (b == sjgl_pkg::BYTE_END) begin
      lead_held = 1'b0;
      pen_col   = org_col;
      pen_row   = org_row;
      return;
    end
    if (lead_held) begin
      missing   = kanji_lookup(lead_val, b, idx);
      lead_held = 1'b0;
      wide      = 1'b1;
    end else if ((b >= 8'h80 && b < 8'hA0) || b >= 8'hE0) begin
      lead_held = 1'b1;
      lead_val  = b;
      return;
    end else if (b == sjgl_pkg::BYTE_NEWLINE) begin
      pen_col = org_col;
      pen_row = sat16(pen_row, 10);
      return;
    end else begin
      if (b < 8'h20)      idx = '0;
      else if (b < 8'h80) idx = b - 8'h20;
      else                idx = b - 8'h40;
    end
    if (on_screen) begin
      placed = 1'b1;
      p = '{wide, idx, missing, pen_col[15:0], pen_row[15:0]};
    end
    pen_col = sat16(pen_col, wide ? 10 : 5);
  endtask

  task automatic send_text(input logic [7:0] b, input bit typed, input placement_t want);
    bit         placed;
    placement_t p;
    while (!calm && $urandom_range(99) < 7) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid   <= 1'b1;
    text_ch.in_byte <= b;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    advance_layout(b, placed, p);
    if (typed)       pending_glyphs.push_back(want);
    else if (placed) pending_glyphs.push_back(p);
  endtask

  task automatic wait_drained();
    text_ch.valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    // bytes that place nothing may still be in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_origins(input int x, input int y);
    logic [sjgl_pkg::ORIGIN_W-1:0] xv;
    logic [sjgl_pkg::ORIGIN_W-1:0] yv;
    bit                            x_first;
    int                            k;
    xv = x[sjgl_pkg::ORIGIN_W-1:0];
    yv = y[sjgl_pkg::ORIGIN_W-1:0];
    x_first = $urandom_range(1);
    for (k = 0; k < 2; k++) begin
      if ((k == 0) == x_first) begin
        cfg_index <= sjgl_pkg::REG_ORIGIN_X;
        cfg_data  <= xv;
        org_col = $signed(xv);
        pen_col = org_col;
      end else begin
        cfg_index <= sjgl_pkg::REG_ORIGIN_Y;
        cfg_data  <= yv;
        org_row = $signed(yv);
        pen_row = org_row;
      end
      cfg_we <= 1'b1;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] random_lead();
    logic [7:0] v;
    v = 8'($urandom_range(31));
    v[7:5] = $urandom_range(1) ? 3'b111 : 3'b100;
    return v;
  endfunction

  task automatic send_random_text(output int n);
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    n = 1;
    if (pick < 30) begin
      send_text(random_lead(), 1'b0, '0);
      if ($urandom_range(9) != 0) b = 8'($urandom_range(8'hFC, 8'h40));
      else                        b = 8'($urandom_range(255, 1));
      send_text(b, 1'b0, '0);
      n = 2;
    end else if (pick < 75) begin
      b = $urandom_range(1) ? 8'($urandom_range(8'h7E, 8'h20)) : 8'($urandom_range(8'hDF, 8'hA0));
      send_text(b, 1'b0, '0);
    end else if (pick < 82) begin
      send_text(sjgl_pkg::BYTE_NEWLINE, 1'b0, '0);
    end else if (pick < 85) begin
      send_text(sjgl_pkg::BYTE_END, 1'b0, '0);
    end else if (pick < 88) begin
      send_text(random_lead(), 1'b0, '0);
      send_text(sjgl_pkg::BYTE_END, 1'b0, '0);
      n = 2;
    end else begin
      send_text(8'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int x, input int y, input int count);
    int sent;
    int n;
    wait_drained();
    set_origins(x, y);
    sent = 0;
    while (sent < count) begin
      send_random_text(n);
      sent += n;
    end
  endtask

  always @(posedge clk) begin
    glyph_ch.ready <= !rst && (calm || $urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (!rst && glyph_ch.valid && glyph_ch.ready) begin
      got = '{glyph_ch.wide, glyph_ch.glyph_index, glyph_ch.glyph_missing,
              glyph_ch.pos_x, glyph_ch.pos_y};
      if (pending_glyphs.size() == 0) begin
        errors++;
        $display("%0t: unexpected glyph: wide=%0d index=%0d missing=%0d x=%0d y=%0d",
                 $time, got.wide, got.glyph_index, got.glyph_missing, got.pos_x, got.pos_y);
      end else begin
        want = pending_glyphs.pop_front();
        if (got.wide !== want.wide || got.glyph_index !== want.glyph_index ||
            got.glyph_missing !== want.glyph_missing || got.pos_x !== want.pos_x ||
            got.pos_y !== want.pos_y) begin
          errors++;
          $display("%0t: glyph mismatch: expected wide=%0d index=%0d missing=%0d x=%0d y=%0d",
                   $time, want.wide, want.glyph_index, want.glyph_missing, want.pos_x,
                   want.pos_y);
          $display("%0t:                 actual   wide=%0d index=%0d missing=%0d x=%0d y=%0d",
                   $time, got.wide, got.glyph_index, got.glyph_missing, got.pos_x, got.pos_y);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (glyph_ch.valid && glyph_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst             <= 1'b1;
    text_ch.valid   <= 1'b0;
    text_ch.in_byte <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= sjgl_pkg::REG_ORIGIN_X;
    cfg_data        <= '0;
    org_col   = 0;
    org_row   = 0;
    pen_col   = 0;
    pen_row   = 0;
    lead_held = 1'b0;
    lead_val  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_text(directed_rows[r].text_byte, directed_rows[r].typed, directed_rows[r].want);

    run_phase(-4096, -4096, 100);
    run_phase(4095, 4095, 60);
    run_phase(470, 262, 100);
    calm = 1'b1;
    run_phase(0, 0, 150);
    calm = 1'b0;
    run_phase(4095, -4096, 60);
    run_phase(-4096, 271, 100);
    repeat (5) run_phase(int'($urandom_range(520)) - 40, int'($urandom_range(320)) - 40, 90);

    run_phase(0, 0, 60);

    wait_drained();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
src/sjgl_pkg.sv
src/sjgl_text_if.sv
src/sjgl_glyph_if.sv
src/sjgl_pen.sv
src/sjgl_glyph.sv
src/sjis_glyph_layout.sv
tb/sv/testbench.sv
